// ===== src/moving_average_filter_top_defines.svh =====
// assertion macros shared by the moving average filter rtl
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/maf_pkg.sv =====
// shared types and constants for the moving average filter
// no dependencies
`timescale 1ns / 1ps

package maf_pkg;

    // sample and average width
    localparam int DATA_W     = 16;
    // default averaging window
    localparam int WINDOW_DEF = 5;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic
    {
        F_IDLE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [1:0]
    {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

    // queue occupancy seen by both sides
    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/moving_average_filter_top.sv =====
// Moving average filter over the last WINDOW signed 16-bit samples. Each input beat
// yields one output beat: the mean of the samples held so far (divisor is the number
// of samples taken, up to WINDOW), truncated toward zero, and window_full once WINDOW
// samples have arrived. The front reads the ring, then forms the sum and updates the
// ring, and hands the exact running sum to a two-entry queue, holding off while the
// queue is full; it takes no new sample until that push. The back divides the sum
// with a bit-serial restoring divider over SUM_W = 16 + clog2(WINDOW) bits, one
// quotient bit per cycle; that divider sets the sustained rate. out_valid rises once
// the back has popped the beat, run the division and loaded the result.
// depends on maf_pkg, maf_front, maf_queue, maf_back
`timescale 1ns / 1ps

module moving_average_filter_top
    import maf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] average,
    output logic                     window_full
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = DATA_W + $clog2(WINDOW);

    queue_status_t          q_status;
    logic                   push;
    logic                   pop;
    logic [SUM_W+CNT_W:0]   push_data;
    logic [SUM_W+CNT_W:0]   pop_data;

    // sample intake and running sum
    maf_front #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    maf_queue #(
        .WIDTH (SUM_W + CNT_W + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // division and result beat
    maf_back #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .window_full (window_full)
    );

endmodule

// ===== src/maf_front.sv =====
// front part: accepts samples, keeps the sample ring, running sum and counters
// depends on maf_pkg, moving_average_filter_top_defines.svh
`timescale 1ns / 1ps
`include "moving_average_filter_top_defines.svh"

module maf_front
    import maf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int CNT_W  = $clog2(WINDOW + 1),
    parameter int SUM_W  = DATA_W + $clog2(WINDOW)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [DATA_W-1:0] sample,
    input  queue_status_t           q_status,
    output logic                    push,
    output logic [SUM_W+CNT_W:0]    push_data
);

    front_state_t              state_reg, state_next;
    logic signed [DATA_W-1:0]  sample_reg;
    logic signed [DATA_W-1:0]  old_reg;
    logic [POS_W-1:0]          wp_reg, wp_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [DATA_W-1:0]  ring_mem [WINDOW];
    logic signed [DATA_W-1:0]  old_val;
    logic                      accept;
    logic                      full_now;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == F_IDLE);

    // entries beyond the fill count were never written and count as zero
    assign full_now = (fill_reg == CNT_W'(WINDOW));
    assign old_val  = full_now ? old_reg : '0;

    // next state and ring update
    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE:
            begin
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                    sum_next   = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);
                    wp_next    = (wp_reg == POS_W'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                    fill_next  = full_now ? fill_reg : fill_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // queued beat: window-full flag, divisor, running sum
    assign push_data = {(fill_next == CNT_W'(WINDOW)), fill_next, sum_next};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    // sample ring with registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            old_reg    <= ring_mem[wp_reg];
        end
        if (push)
        begin
            ring_mem[wp_reg] <= sample_reg;
        end
    end

    `MAF_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= CNT_W'(WINDOW), "fill count above window")
    `MAF_ASSERT_NOW(a_wp_range, 1'b1, wp_reg <= POS_W'(WINDOW - 1), "write position out of ring")
    `MAF_ASSERT_NEXT(a_wp_follows_fill, push && !full_now, wp_reg == POS_W'(fill_reg) || fill_reg == CNT_W'(WINDOW), "write position lost track of fill")

endmodule

// ===== src/maf_queue.sv =====
// two-entry queue between the front and back parts
// depends on maf_pkg, moving_average_filter_top_defines.svh
`timescale 1ns / 1ps
`include "moving_average_filter_top_defines.svh"

module maf_queue
    import maf_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0]  entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_reg];

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

    `MAF_ASSERT_NOW(a_q_cnt, 1'b1, cnt_reg <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

// ===== src/maf_back.sv =====
// back part: bit-serial division of the running sum by the fill count
// depends on maf_pkg, moving_average_filter_top_defines.svh
`timescale 1ns / 1ps
`include "moving_average_filter_top_defines.svh"

module maf_back
    import maf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int CNT_W  = $clog2(WINDOW + 1),
    parameter int SUM_W  = DATA_W + $clog2(WINDOW)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  queue_status_t            q_status,
    input  logic [SUM_W+CNT_W:0]     pop_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] average,
    output logic                     window_full
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    back_state_t               state_reg, state_next;
    logic [SUM_W-1:0]          dq_reg, dq_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]          div_reg;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic                      neg_reg;
    logic                      flag_reg;
    logic signed [DATA_W-1:0]  avg_reg;
    logic                      wf_reg;
    logic                      ovalid_reg, ovalid_next;
    logic                      load_out;
    logic signed [SUM_W-1:0]   q_sum;
    logic [CNT_W-1:0]          q_cnt;
    logic                      q_flag;
    logic [SUM_W-1:0]          q_mag;
    logic [CNT_W:0]            rem_sh;
    logic [CNT_W:0]            rem_sub;
    logic                      qbit;
    logic [DATA_W-1:0]         quo;

    assign {q_flag, q_cnt, q_sum} = pop_data;
    assign q_mag = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);

    // one restoring division step
    assign rem_sh  = {rem_reg, dq_reg[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign qbit    = (rem_sh >= {1'b0, div_reg});
    assign quo     = dq_reg[DATA_W-1:0];

    // next state and divider datapath
    always_comb
    begin
        state_next  = state_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        iter_next   = iter_reg;
        pop         = 1'b0;
        load_out    = 1'b0;
        ovalid_next = ovalid_reg && !out_ready;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    dq_next    = q_mag;
                    rem_next   = '0;
                    iter_next  = ITER_W'(SUM_W);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                dq_next   = {dq_reg[SUM_W-2:0], qbit};
                rem_next  = qbit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                iter_next = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    load_out    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            iter_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iter_reg   <= iter_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // divider and output beat payload
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (pop)
        begin
            div_reg  <= q_cnt;
            neg_reg  <= q_sum[SUM_W-1];
            flag_reg <= q_flag;
        end
        if (load_out)
        begin
            avg_reg <= neg_reg ? DATA_W'(-quo) : quo;
            wf_reg  <= flag_reg;
        end
    end

    assign out_valid   = ovalid_reg;
    assign average     = avg_reg;
    assign window_full = wf_reg;

    `MAF_ASSERT_NOW(a_rem_below_div, state_reg == B_DIV, rem_reg < div_reg, "remainder not below divisor")
    `MAF_ASSERT_NOW(a_div_nonzero, state_reg == B_DIV, div_reg != '0, "division by zero fill count")
    `MAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(average), "result beat dropped while stalled")

endmodule
